@@ rtl/sif_pkg.sv @@
package sif_pkg;

    localparam int HEADER_BYTES_DEF = 2;
    localparam int QUEUE_DEPTH_DEF  = 4;

    // input modes
    localparam logic MODE_START = 1'b0;
    localparam logic MODE_PARAM = 1'b1;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_LEN_OVF  = 2'd1;
    localparam logic [1:0] ST_CAPACITY = 2'd2;

    // command kinds passed from front to back
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_REJECT = 2'd1;
    localparam logic [1:0] CMD_PARAM  = 2'd2;

    // config register indexes
    localparam logic REG_HEADER_BYTE = 1'b0;
    localparam logic REG_MAX_FRAME   = 1'b1;

    typedef struct packed {
        logic       mode;
        logic [7:0] device_id;
        logic [7:0] instruction_code;
        logic [7:0] param_count;
        logic [7:0] param_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_end;
        logic [1:0] status;
        logic [7:0] frame_length;
    } res_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       closes;   // checksum beat follows
        logic [7:0] b_data;   // device id, or parameter byte
        logic [7:0] b_len;
        logic [7:0] b_inst;
        logic [7:0] b_chk;
        logic [7:0] total;
        logic [1:0] status;
    } cmd_t;

endpackage

@@ rtl/servo_instruction_packet_framer_unit.sv @@
// Channel   Handshake             Payload      Notes
// input     push / full           item         start or parameter byte
// result    empty / pop           result       one frame byte per beat
// config    psel/penable/pwrite   paddr/pwdata header_byte @0, max_frame_bytes @4
//
// Parameter beats stream at one per cycle unless full; the last one yields two result beats.
// A start yields HEADER_BYTES + 3 result beats (+1 with no parameters), one per cycle while
// pop keeps up, from the back end's single result register; a rejected start yields one.
// The command queue (QUEUE_DEPTH entries) lets the front keep accepting while the back drains.
// Reset clears frame state, queue pointers and the result valid flag; no clearing pass.
// full rises only when the command queue is full; a stalled pop holds the result.
module servo_instruction_packet_framer_unit #(
    parameter int HEADER_BYTES = sif_pkg::HEADER_BYTES_DEF,
    parameter int QUEUE_DEPTH  = sif_pkg::QUEUE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  sif_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output sif_pkg::res_item_t result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import sif_pkg::*;

    logic [7:0] header_byte_reg;
    logic [7:0] max_frame_reg;
    logic       cfg_wr;

    logic       cmd_push;
    cmd_t       cmd;
    cmd_t       head;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_byte_reg <= 8'hFF;
            max_frame_reg   <= 8'hFF;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_HEADER_BYTE: header_byte_reg <= pwdata[7:0];
                REG_MAX_FRAME:   max_frame_reg   <= pwdata[7:0];
                default:         header_byte_reg <= header_byte_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_HEADER_BYTE: prdata = {24'd0, header_byte_reg};
            REG_MAX_FRAME:   prdata = {24'd0, max_frame_reg};
            default:         prdata = 32'd0;
        endcase
    end

    assign full = q_full;

    sif_front #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .item            (item),
        .q_full          (q_full),
        .max_frame_bytes (max_frame_reg),
        .cmd_push        (cmd_push),
        .cmd             (cmd)
    );

    sif_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd),
        .rd_en   (q_pop),
        .rd_data (head),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    sif_back #(
        .HEADER_BYTES (HEADER_BYTES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .header_byte (header_byte_reg),
        .pop         (pop),
        .empty       (empty),
        .result      (result)
    );

endmodule

@@ rtl/sif_front.sv @@
module sif_front #(
    parameter int HEADER_BYTES = sif_pkg::HEADER_BYTES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sif_pkg::in_item_t item,
    input  logic             q_full,
    input  logic [7:0]       max_frame_bytes,
    output logic             cmd_push,
    output sif_pkg::cmd_t    cmd
);
    import sif_pkg::*;

    logic       frame_open_reg, frame_open_next;
    logic [7:0] params_left_reg, params_left_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic [7:0] frame_total_reg, frame_total_next;

    logic       acc;
    logic [8:0] total9;
    logic [7:0] lenf;
    logic [7:0] start_sum;
    logic [7:0] param_sum;

    assign acc       = push && !q_full;
    assign total9    = {1'b0, item.param_count} + 9'(HEADER_BYTES + 4);
    assign lenf      = item.param_count + 8'd2;
    assign start_sum = item.device_id + lenf + item.instruction_code;
    assign param_sum = running_sum_reg + item.param_byte;

    always_comb
    begin
        frame_open_next  = frame_open_reg;
        params_left_next = params_left_reg;
        running_sum_next = running_sum_reg;
        frame_total_next = frame_total_reg;
        cmd_push         = 1'b0;
        cmd              = '0;
        if (acc)
        begin
            if (item.mode == MODE_START)
            begin
                frame_open_next = 1'b0;
                cmd_push        = 1'b1;
                if (total9[8])
                begin
                    cmd.kind   = CMD_REJECT;
                    cmd.status = ST_LEN_OVF;
                    cmd.total  = 8'd0;
                end
                else if (total9[7:0] > max_frame_bytes)
                begin
                    cmd.kind   = CMD_REJECT;
                    cmd.status = ST_CAPACITY;
                    cmd.total  = total9[7:0];
                end
                else
                begin
                    frame_total_next = total9[7:0];
                    params_left_next = item.param_count;
                    running_sum_next = start_sum;
                    frame_open_next  = (item.param_count != 8'd0);
                    cmd.kind   = CMD_START;
                    cmd.status = ST_OK;
                    cmd.closes = (item.param_count == 8'd0);
                    cmd.b_data = item.device_id;
                    cmd.b_len  = lenf;
                    cmd.b_inst = item.instruction_code;
                    cmd.b_chk  = ~start_sum;
                    cmd.total  = total9[7:0];
                end
            end
            else if (frame_open_reg)
            begin
                // drop parameters that arrive with no open frame
                cmd_push         = 1'b1;
                running_sum_next = param_sum;
                params_left_next = params_left_reg - 8'd1;
                cmd.kind   = CMD_PARAM;
                cmd.status = ST_OK;
                cmd.closes = (params_left_reg == 8'd1);
                cmd.b_data = item.param_byte;
                cmd.b_chk  = ~param_sum;
                cmd.total  = frame_total_reg;
                if (params_left_reg == 8'd1)
                begin
                    frame_open_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg  <= 1'b0;
            params_left_reg <= 8'd0;
            running_sum_reg <= 8'd0;
            frame_total_reg <= 8'd0;
        end
        else
        begin
            frame_open_reg  <= frame_open_next;
            params_left_reg <= params_left_next;
            running_sum_reg <= running_sum_next;
            frame_total_reg <= frame_total_next;
        end
    end

    a_open_has_params: assert property (@(posedge clk) disable iff (!rst_n)
        frame_open_reg |-> params_left_reg != 8'd0)
        else $error("open frame with no parameters left");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> !q_full)
        else $error("command pushed into full queue");

    a_open_total: assert property (@(posedge clk) disable iff (!rst_n)
        frame_open_reg |-> frame_total_reg >= 8'(HEADER_BYTES + 5))
        else $error("open frame total too small");

endmodule

@@ rtl/sif_cmd_queue.sv @@
module sif_cmd_queue #(
    parameter int DEPTH = sif_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  sif_pkg::cmd_t wr_data,
    input  logic          rd_en,
    output sif_pkg::cmd_t rd_data,
    output logic          q_full,
    output logic          q_empty
);
    import sif_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          slots [DEPTH];
    logic [IW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [IW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_wr, do_rd;

    assign q_full  = (count_reg == CW'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == IW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == IW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/sif_back.sv @@
module sif_back #(
    parameter int HEADER_BYTES = sif_pkg::HEADER_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  sif_pkg::cmd_t      head,
    input  logic               q_empty,
    output logic               q_pop,
    input  logic [7:0]         header_byte,
    input  logic               pop,
    output logic               empty,
    output sif_pkg::res_item_t result
);
    import sif_pkg::*;

    localparam int BW = $clog2(HEADER_BYTES + 4);
    localparam logic [BW-1:0] BEAT_ID   = BW'(HEADER_BYTES);
    localparam logic [BW-1:0] BEAT_LEN  = BW'(HEADER_BYTES + 1);
    localparam logic [BW-1:0] BEAT_INST = BW'(HEADER_BYTES + 2);
    localparam logic [BW-1:0] BEAT_CHK  = BW'(HEADER_BYTES + 3);

    logic [BW-1:0] beat_reg, beat_next;
    logic          out_valid_reg, out_valid_next;
    res_item_t     out_data_reg, out_data_next;

    logic          head_valid;
    logic          adv;
    logic          final_beat;
    res_item_t     beat_out;

    assign head_valid = !q_empty;
    assign adv        = head_valid && (!out_valid_reg || pop);

    always_comb
    begin
        beat_out              = '0;
        beat_out.status       = head.status;
        beat_out.frame_length = head.total;
        final_beat            = 1'b0;
        unique case (head.kind)
            CMD_START:
            begin
                if (beat_reg < BEAT_ID)
                begin
                    beat_out.out_byte = header_byte;
                end
                else if (beat_reg == BEAT_ID)
                begin
                    beat_out.out_byte = head.b_data;
                end
                else if (beat_reg == BEAT_LEN)
                begin
                    beat_out.out_byte = head.b_len;
                end
                else if (beat_reg == BEAT_INST)
                begin
                    beat_out.out_byte = head.b_inst;
                    beat_out.run_last = !head.closes;
                    final_beat        = !head.closes;
                end
                else
                begin
                    beat_out.out_byte  = head.b_chk;
                    beat_out.run_last  = 1'b1;
                    beat_out.frame_end = 1'b1;
                    final_beat         = 1'b1;
                end
            end
            CMD_PARAM:
            begin
                if (beat_reg == '0)
                begin
                    beat_out.out_byte = head.b_data;
                    beat_out.run_last = !head.closes;
                    final_beat        = !head.closes;
                end
                else
                begin
                    beat_out.out_byte  = head.b_chk;
                    beat_out.run_last  = 1'b1;
                    beat_out.frame_end = 1'b1;
                    final_beat         = 1'b1;
                end
            end
            default:
            begin
                // rejected start: one error beat
                beat_out.run_last = 1'b1;
                final_beat        = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        beat_next      = beat_reg;
        out_valid_next = out_valid_reg && !pop;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        if (adv)
        begin
            out_valid_next = 1'b1;
            out_data_next  = beat_out;
            if (final_beat)
            begin
                beat_next = '0;
                q_pop     = 1'b1;
            end
            else
            begin
                beat_next = beat_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            beat_reg      <= beat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign empty  = !out_valid_reg;
    assign result = out_data_reg;

    a_beat_range: assert property (@(posedge clk) disable iff (!rst_n)
        beat_reg <= BEAT_CHK)
        else $error("beat counter out of range");

    a_idle_beat: assert property (@(posedge clk) disable iff (!rst_n)
        q_empty |-> beat_reg == '0)
        else $error("beat counter left mid-command with queue empty");

    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.frame_end) |-> out_data_reg.run_last)
        else $error("frame end without run last");

endmodule

@@ tb/servo_instruction_packet_framer_unit_tb.sv @@
`timescale 1ns / 1ps

module servo_instruction_packet_framer_unit_tb;
    import sif_pkg::*;

    localparam int HDR_BEATS = HEADER_BYTES_DEF;

    class frame_scoreboard;
        logic [7:0] hdr_val;
        logic [7:0] cap_val;
        bit         in_frame;
        logic [7:0] params_due;
        logic [7:0] sum_acc;
        logic [7:0] frame_bytes;
        res_item_t  beats_due[$];
        int         errors;

        function new();
            hdr_val     = 8'hFF;
            cap_val     = 8'hFF;
            in_frame    = 1'b0;
            params_due  = '0;
            sum_acc     = '0;
            frame_bytes = '0;
            errors      = 0;
        endfunction

        function void set_reg(logic ridx, logic [7:0] val);
            if (ridx == REG_HEADER_BYTE)
                hdr_val = val;
            else
                cap_val = val;
        endfunction

        function void add_beat(logic [7:0] b, logic last, logic fend, logic [1:0] st,
                               logic [7:0] flen);
            res_item_t r;
            r.out_byte     = b;
            r.run_last     = last;
            r.frame_end    = fend;
            r.status       = st;
            r.frame_length = flen;
            beats_due.push_back(r);
        endfunction

        function void note_item(in_item_t it);
            int unsigned tot;
            logic [7:0]  lenf;
            if (it.mode == MODE_START) begin
                in_frame = 1'b0;
                tot  = int'(it.param_count) + HDR_BEATS + 4;
                lenf = it.param_count + 8'd2;
                if (tot > 255) begin
                    add_beat(8'h00, 1'b1, 1'b0, ST_LEN_OVF, 8'h00);
                end else if (tot > int'(cap_val)) begin
                    add_beat(8'h00, 1'b1, 1'b0, ST_CAPACITY, tot[7:0]);
                end else begin
                    frame_bytes = tot[7:0];
                    params_due  = it.param_count;
                    sum_acc     = it.device_id + lenf + it.instruction_code;
                    for (int h = 0; h < HDR_BEATS; h++)
                        add_beat(hdr_val, 1'b0, 1'b0, ST_OK, frame_bytes);
                    add_beat(it.device_id, 1'b0, 1'b0, ST_OK, frame_bytes);
                    add_beat(lenf, 1'b0, 1'b0, ST_OK, frame_bytes);
                    if (it.param_count == 0) begin
                        add_beat(it.instruction_code, 1'b0, 1'b0, ST_OK, frame_bytes);
                        add_beat(~sum_acc, 1'b1, 1'b1, ST_OK, frame_bytes);
                    end else begin
                        add_beat(it.instruction_code, 1'b1, 1'b0, ST_OK, frame_bytes);
                        in_frame = 1'b1;
                    end
                end
            end else if (in_frame) begin
                sum_acc    = sum_acc + it.param_byte;
                params_due = params_due - 8'd1;
                if (params_due == 0) begin
                    add_beat(it.param_byte, 1'b0, 1'b0, ST_OK, frame_bytes);
                    add_beat(~sum_acc, 1'b1, 1'b1, ST_OK, frame_bytes);
                    in_frame = 1'b0;
                end else begin
                    add_beat(it.param_byte, 1'b1, 1'b0, ST_OK, frame_bytes);
                end
            end
        endfunction

        function void check_beat(res_item_t got);
            res_item_t want;
            if (beats_due.size() == 0) begin
                $error("unexpected result beat: %h", got);
                errors++;
                return;
            end
            want = beats_due.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.run_last !== want.run_last) begin
                $error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
                errors++;
            end
            if (got.frame_end !== want.frame_end) begin
                $error("frame_end: expected %0b, got %0b", want.frame_end, got.frame_end);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.frame_length !== want.frame_length) begin
                $error("frame_length: expected %0d, got %0d",
                       want.frame_length, got.frame_length);
                errors++;
            end
        endfunction

        function int pending();
            return beats_due.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    in_item_t    item = '0;
    logic        empty;
    logic        pop = 1'b0;
    res_item_t   result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    frame_scoreboard sb = new();
    int  burst_left = 0;
    bit  hold_req = 1'b0;
    bit  hold_served = 1'b0;

    servo_instruction_packet_framer_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && !full)
                sb.note_item(item);
            if (pop && !empty)
                sb.check_beat(result);
        end
    end

    // receiver: pops in a randomly chosen pattern: always, coin-flip or one in eight
    initial
    begin : receiver
        int rx_mode;
        int mode_left;
        rx_mode   = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_served)
            begin
                // hold off long enough for the command queue to fill
                hold_served = 1'b1;
                pop <= 1'b0;
                for (int k = 0; k < 400; k++)
                    @(posedge clk);
            end
            if (mode_left == 0)
            begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(5, 60);
            end
            mode_left--;
            case (rx_mode)
                0, 1:    pop <= 1'b1;
                2:       pop <= 1'($urandom_range(0, 1));
                default: pop <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    initial
    begin
        #3000000;
        $display("servo_instruction_packet_framer_unit_tb: errors");
        $finish;
    end

    function automatic in_item_t mk_item(logic m, logic [7:0] id, logic [7:0] inst,
                                         logic [7:0] cnt, logic [7:0] pb);
        in_item_t it;
        it.mode             = m;
        it.device_id        = id;
        it.instruction_code = inst;
        it.param_count      = cnt;
        it.param_byte       = pb;
        return it;
    endfunction

    function automatic in_item_t rand_start(logic [7:0] cnt);
        return mk_item(MODE_START, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       cnt, 8'($urandom_range(0, 255)));
    endfunction

    function automatic in_item_t rand_param();
        return mk_item(MODE_PARAM, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endfunction

    task automatic send(in_item_t it);
        int gap;
        push <= 1'b1;
        item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 10);
            gap = $urandom_range(1, 5);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        else
        begin
            burst_left--;
        end
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        // let the monitor note the last accepted item first
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic ridx, logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {ridx, 2'b00};
        pwdata  <= {24'h0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(ridx, val);
        @(posedge clk);
    endtask

    task automatic set_config(logic [7:0] hdr, logic [7:0] cap);
        write_reg(REG_HEADER_BYTE, hdr);
        write_reg(REG_MAX_FRAME, cap);
    endtask

    task automatic run_traffic(int budget);
        int done_n;
        int r;
        int cnt;
        int n_par;
        done_n = 0;
        while (done_n < budget)
        begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 24) == 0)
                cnt = $urandom_range(41, 255);
            else
                cnt = $urandom_range(0, 8);
            send(rand_start(8'(cnt)));
            done_n++;
            if (r < 80)
                n_par = (cnt <= 40) ? cnt : $urandom_range(0, 10);
            else if (r < 90)
                n_par = (cnt == 0) ? 0 : $urandom_range(0, (cnt > 10 ? 10 : cnt - 1));
            else
                n_par = $urandom_range(0, 12);
            for (int k = 0; k < n_par; k++)
            begin
                send(rand_param());
                done_n++;
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_config(8'hFF, 8'hFF);
        // stray parameter, empty frame, length overflow at both edges
        send(mk_item(MODE_PARAM, 8'h00, 8'h00, 8'h00, 8'hFF));
        send(mk_item(MODE_START, 8'h00, 8'h00, 8'h00, 8'hFF));
        send(mk_item(MODE_START, 8'hFF, 8'hFF, 8'hFF, 8'h00));
        send(mk_item(MODE_START, 8'h5A, 8'hA5, 8'd250, 8'h00));
        send(mk_item(MODE_START, 8'hFF, 8'hFF, 8'd1, 8'h00));
        send(mk_item(MODE_PARAM, 8'h00, 8'h00, 8'h00, 8'hFF));
        send(mk_item(MODE_START, 8'h12, 8'h03, 8'd3, 8'h00));
        send(mk_item(MODE_PARAM, 8'hFF, 8'hFF, 8'hFF, 8'h00));
        send(mk_item(MODE_PARAM, 8'h00, 8'h00, 8'h00, 8'hFF));
        send(mk_item(MODE_PARAM, 8'h00, 8'h00, 8'h00, 8'h80));
        // restart over an open frame
        send(mk_item(MODE_START, 8'h21, 8'h04, 8'd2, 8'h00));
        send(mk_item(MODE_PARAM, 8'h00, 8'h00, 8'h00, 8'h55));
        send(mk_item(MODE_START, 8'h01, 8'h02, 8'd0, 8'h00));
        // largest frame that fits, then drop it
        send(mk_item(MODE_START, 8'hAA, 8'h55, 8'd249, 8'h00));
        for (int k = 0; k < 3; k++)
            send(mk_item(MODE_PARAM, 8'h00, 8'h00, 8'h00, 8'h01));
        send(mk_item(MODE_START, 8'hFF, 8'h00, 8'd0, 8'h00));
        send(mk_item(MODE_PARAM, 8'h00, 8'h00, 8'h00, 8'h7E));
        run_traffic(90);
        wait_idle();

        set_config(8'h00, 8'd10);
        // capacity edge, and overflow taking precedence over capacity
        send(mk_item(MODE_START, 8'h33, 8'h44, 8'd4, 8'h00));
        for (int k = 0; k < 4; k++)
            send(rand_param());
        send(mk_item(MODE_START, 8'h33, 8'h44, 8'd5, 8'h00));
        send(mk_item(MODE_START, 8'h33, 8'h44, 8'hFF, 8'h00));
        hold_req = 1'b1;
        run_traffic(70);
        wait_idle();

        set_config(8'hA5, 8'h00);
        run_traffic(30);
        wait_idle();

        set_config(8'($urandom_range(0, 255)), 8'hFF);
        run_traffic(100);
        wait_idle();

        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(6, 40)));
        run_traffic(100);
        wait_idle();

        set_config(8'h5A, 8'd6);
        run_traffic(60);

        push <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
        if (sb.errors == 0)
            $display("servo_instruction_packet_framer_unit_tb: clean");
        else
            $display("servo_instruction_packet_framer_unit_tb: errors");
        $finish;
    end

endmodule

@@ files.f @@
rtl/sif_pkg.sv
rtl/sif_front.sv
rtl/sif_cmd_queue.sv
rtl/sif_back.sv
rtl/servo_instruction_packet_framer_unit.sv
tb/servo_instruction_packet_framer_unit_tb.sv
